// ===== rtl/core/bsra_pkg.sv =====
// Shared constants for the bridge converter serial readout and averager.
package bsra_pkg;

  localparam int unsigned SampleBitsDef = 24;
  localparam int unsigned MaxAverageDef = 1024;

  localparam int unsigned CfgDataW  = 25;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned AvgCountW = 11;
  localparam int unsigned TimeoutW  = 25;
  localparam int unsigned HoldW     = 16;

  localparam logic [CfgAddrW-1:0] CFG_AVG_COUNT = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_HOLD      = 2'd2;

  localparam logic [AvgCountW-1:0] AvgCountRst = 11'd1;
  localparam logic [TimeoutW-1:0]  TimeoutRst  = 25'd23232323;
  localparam logic [HoldW-1:0]     HoldRst     = 16'd52;

  localparam int unsigned ReqW = 2;

  localparam logic [ReqW-1:0] REQ_TICK  = 2'd0;
  localparam logic [ReqW-1:0] REQ_READ  = 2'd1;
  localparam logic [ReqW-1:0] REQ_RESET = 2'd2;
  localparam logic [ReqW-1:0] REQ_PDOWN = 2'd3;

endpackage

// ===== rtl/core/bsra_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bsra_div #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned StepW = $clog2(NUM_W + 1);

  logic             busy_q;
  logic [StepW-1:0] step_q;
  logic             done_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_d;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};
  assign rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(NUM_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      quo_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/core/bridge_adc_serial_readout_averager.sv =====
// Top level: two-wire bridge converter readout with averaging.
//
// Each input item is one serial clock half-period tick: a request code and the
// sampled data/ready pin. Each accepted item yields exactly one result item:
// the clock level for the next half period, done, status, the averaged code
// and busy. A read runs average_count conversions (0 as 1, max MAX_AVERAGE) of
// SAMPLE_BITS bits each, reporting the truncated mean of the offset-binary codes.
// The result of every tick is registered in the cycle after acceptance, except
// the last tick of a read, whose result waits for the restoring divider, which
// produces one quotient bit per cycle. Throughput is one item per cycle outside
// that divide while the receiver keeps taking results.
// The input is ready when no divide runs and the output register is empty or
// is being taken in the same cycle; a stalled receiver therefore holds off
// the next item, and the pending result stays unchanged.
// Configuration writes take effect at the next edge; write only while idle.
// Reset returns the sequence to idle, its clock level low, config to defaults.
module bridge_adc_serial_readout_averager #(
  parameter int unsigned SAMPLE_BITS = bsra_pkg::SampleBitsDef,
  parameter int unsigned MAX_AVERAGE = bsra_pkg::MaxAverageDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsra_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [bsra_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bsra_pkg::ReqW-1:0]     req_type_i,
  input  logic                          data_pin_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          clock_pin_o,
  output logic                          done_res_o,
  output logic                          status_o,
  output logic [SAMPLE_BITS-1:0]        average_code_o,
  output logic                          busy_res_o
);

  import bsra_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_AVERAGE + 1);
  localparam int unsigned SumW  = SAMPLE_BITS + CntW;
  localparam int unsigned BitW  = $clog2(SAMPLE_BITS + 1);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_WAIT  = 4'd1;
  localparam logic [3:0] PH_SHI   = 4'd2;
  localparam logic [3:0] PH_SLO   = 4'd3;
  localparam logic [3:0] PH_REL   = 4'd4;
  localparam logic [3:0] PH_FIN   = 4'd5;
  localparam logic [3:0] PH_RHOLD = 4'd6;
  localparam logic [3:0] PH_REND  = 4'd7;
  localparam logic [3:0] PH_PHOLD = 4'd8;

  localparam logic SQ_IDLE = 1'b0;
  localparam logic SQ_DIV  = 1'b1;

  localparam logic [SAMPLE_BITS-1:0] TopBit = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [AvgCountW-1:0] avg_cnt_q;
  logic [TimeoutW-1:0]  timeout_q;
  logic [HoldW-1:0]     hold_q;

  logic [3:0]             phase_q, phase_d;
  logic [SAMPLE_BITS-1:0] shift_q, shift_d;
  logic [BitW-1:0]        bits_q, bits_d;
  logic [CntW-1:0]        conv_q, conv_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic [TimeoutW-1:0]    wait_q, wait_d;
  logic [HoldW-1:0]       hcnt_q, hcnt_d;
  logic                   clk_lvl_q, clk_lvl_d;

  logic seq_q, seq_d;

  logic                   out_valid_q, out_valid_d;
  logic                   clock_pin_q, clock_pin_d;
  logic                   done_q, done_d;
  logic                   status_q, status_d;
  logic [SAMPLE_BITS-1:0] avg_q, avg_d;
  logic                   busy_q, busy_d;

  logic [31:0]         cnt_ext;
  logic [CntW-1:0]     eff_cnt;
  logic [HoldW-1:0]    eff_hold;
  logic                accept;
  logic                step_done;
  logic                step_status;
  logic                div_start;
  logic                div_done;
  logic [SumW-1:0]     div_quo;
  logic [CntW-1:0]     conv_inc;
  logic [BitW-1:0]     bits_inc;
  logic [TimeoutW-1:0] wait_inc;

  assign cnt_ext  = 32'(avg_cnt_q);
  assign eff_cnt  = (cnt_ext == 32'd0) ? CntW'(1) :
                    ((cnt_ext > MAX_AVERAGE) ? CntW'(MAX_AVERAGE) : CntW'(cnt_ext));
  assign eff_hold = (hold_q == '0) ? HoldW'(1) : hold_q;

  assign in_ready_o = (seq_q == SQ_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign conv_inc = conv_q + 1'b1;
  assign bits_inc = bits_q + 1'b1;
  assign wait_inc = wait_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    shift_d     = shift_q;
    bits_d      = bits_q;
    conv_d      = conv_q;
    sum_d       = sum_q;
    wait_d      = wait_q;
    hcnt_d      = hcnt_q;
    clk_lvl_d   = clk_lvl_q;
    step_done   = 1'b0;
    step_status = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (req_type_i == REQ_READ) begin
          sum_d     = '0;
          conv_d    = '0;
          wait_d    = '0;
          clk_lvl_d = 1'b0;
          phase_d   = PH_WAIT;
        end else if (req_type_i == REQ_RESET || req_type_i == REQ_PDOWN) begin
          hcnt_d    = HoldW'(1);
          clk_lvl_d = 1'b1;
          phase_d   = (req_type_i == REQ_RESET) ? PH_RHOLD : PH_PHOLD;
        end
      end
      PH_WAIT: begin
        if (!data_pin_i) begin
          shift_d   = '0;
          bits_d    = '0;
          clk_lvl_d = 1'b1;
          phase_d   = PH_SHI;
        end else begin
          wait_d = wait_inc;
          if (wait_inc >= timeout_q) begin
            step_done   = 1'b1;
            step_status = 1'b1;
            clk_lvl_d   = 1'b0;
            phase_d     = PH_IDLE;
          end
        end
      end
      PH_SHI: begin
        clk_lvl_d = 1'b0;
        phase_d   = PH_SLO;
      end
      PH_SLO: begin
        shift_d   = {shift_q[SAMPLE_BITS-2:0], data_pin_i};
        bits_d    = bits_inc;
        clk_lvl_d = 1'b1;
        phase_d   = (bits_inc >= BitW'(SAMPLE_BITS)) ? PH_REL : PH_SHI;
      end
      PH_REL: begin
        clk_lvl_d = 1'b0;
        sum_d     = sum_q + SumW'(shift_q ^ TopBit);
        conv_d    = conv_inc;
        if (conv_inc >= eff_cnt) begin
          phase_d = PH_FIN;
        end else begin
          wait_d  = '0;
          phase_d = PH_WAIT;
        end
      end
      PH_FIN: begin
        step_done   = 1'b1;
        step_status = !data_pin_i;
        clk_lvl_d   = 1'b0;
        phase_d     = PH_IDLE;
      end
      PH_RHOLD: begin
        if (hcnt_q >= eff_hold) begin
          clk_lvl_d = 1'b0;
          phase_d   = PH_REND;
        end else begin
          hcnt_d = hcnt_q + 1'b1;
        end
      end
      PH_REND: begin
        step_done   = 1'b1;
        step_status = !data_pin_i;
        phase_d     = PH_IDLE;
      end
      PH_PHOLD: begin
        if (hcnt_q >= eff_hold) begin
          step_done   = 1'b1;
          step_status = !data_pin_i;
          phase_d     = PH_IDLE;
        end else begin
          hcnt_d = hcnt_q + 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  assign div_start = accept && (phase_q == PH_FIN);

  always_comb begin
    seq_d       = seq_q;
    out_valid_d = out_valid_q && !out_ready_i;
    clock_pin_d = clock_pin_q;
    done_d      = done_q;
    status_d    = status_q;
    avg_d       = avg_q;
    busy_d      = busy_q;
    unique case (seq_q)
      SQ_IDLE: begin
        if (accept) begin
          clock_pin_d = clk_lvl_d;
          done_d      = step_done;
          status_d    = step_status;
          avg_d       = '0;
          busy_d      = (phase_d != PH_IDLE);
          if (div_start) begin
            seq_d = SQ_DIV;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      SQ_DIV: begin
        if (div_done) begin
          avg_d       = div_quo[SAMPLE_BITS-1:0];
          out_valid_d = 1'b1;
          seq_d       = SQ_IDLE;
        end
      end
      default: begin
        seq_d = SQ_IDLE;
      end
    endcase
  end

  bsra_div #(
    .NUM_W (SumW),
    .DEN_W (CntW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (eff_cnt),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_cnt_q   <= AvgCountRst;
      timeout_q   <= TimeoutRst;
      hold_q      <= HoldRst;
      phase_q     <= PH_IDLE;
      shift_q     <= '0;
      bits_q      <= '0;
      conv_q      <= '0;
      sum_q       <= '0;
      wait_q      <= '0;
      hcnt_q      <= '0;
      clk_lvl_q   <= 1'b0;
      seq_q       <= SQ_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_AVG_COUNT: avg_cnt_q <= cfg_wdata_i[AvgCountW-1:0];
          CFG_TIMEOUT:   timeout_q <= cfg_wdata_i[TimeoutW-1:0];
          CFG_HOLD:      hold_q    <= cfg_wdata_i[HoldW-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase_q   <= phase_d;
        shift_q   <= shift_d;
        bits_q    <= bits_d;
        conv_q    <= conv_d;
        sum_q     <= sum_d;
        wait_q    <= wait_d;
        hcnt_q    <= hcnt_d;
        clk_lvl_q <= clk_lvl_d;
      end
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clock_pin_q <= clock_pin_d;
    done_q      <= done_d;
    status_q    <= status_d;
    avg_q       <= avg_d;
    busy_q      <= busy_d;
  end

  assign out_valid_o    = out_valid_q;
  assign clock_pin_o    = clock_pin_q;
  assign done_res_o     = done_q;
  assign status_o       = status_q;
  assign average_code_o = avg_q;
  assign busy_res_o     = busy_q;

endmodule

// ===== tb/tb_bridge_adc_serial_readout_averager.sv =====
// Self-checking testbench for the bridge converter serial readout and averager.
module tb_bridge_adc_serial_readout_averager;
  timeunit 1ns;
  timeprecision 1ps;

  import bsra_pkg::*;

  localparam int unsigned SampleBits  = SampleBitsDef;
  localparam int unsigned DrainCycles = SampleBitsDef + $clog2(MaxAverageDef + 1) + 8;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned StallCycles = 300;
  localparam int unsigned PrintLimit  = 50;
  localparam logic [SampleBits-1:0] TopBit = {1'b1, {(SampleBits-1){1'b0}}};

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_WAIT_READY,
    SEQ_CLK_HIGH,
    SEQ_CLK_LOW,
    SEQ_RELEASE,
    SEQ_FINISH,
    SEQ_RST_HOLD,
    SEQ_RST_END,
    SEQ_PD_HOLD
  } seq_e;

  typedef struct packed {
    logic [ReqW-1:0] req;
    logic            pin;
  } tick_t;

  typedef struct packed {
    logic                  clock_pin;
    logic                  done;
    logic                  status;
    logic [SampleBits-1:0] code;
    logic                  busy;
  } readout_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i  = CFG_AVG_COUNT;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [ReqW-1:0]     req_type_i  = REQ_TICK;
  logic                data_pin_i  = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                clock_pin_o;
  logic                done_res_o;
  logic                status_o;
  logic [SampleBits-1:0] average_code_o;
  logic                busy_res_o;

  bridge_adc_serial_readout_averager dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .data_pin_i     (data_pin_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .clock_pin_o    (clock_pin_o),
    .done_res_o     (done_res_o),
    .status_o       (status_o),
    .average_code_o (average_code_o),
    .busy_res_o     (busy_res_o)
  );

  tick_t    pending_ticks[$];
  readout_t expected_readouts[$];
  readout_t want_readout;

  int unsigned tx_idle_pct = 20;
  int unsigned rx_idle_pct = 52;
  int unsigned stall_req   = 0;
  int unsigned stall_ack   = 0;
  int unsigned stall_left  = 0;
  int unsigned error_count = 0;
  int unsigned readout_count = 0;
  int unsigned ticks_queued  = 0;
  int unsigned cycle_count   = 0;

  // Register copies
  logic [AvgCountW-1:0] avg_count_reg = AvgCountRst;
  logic [TimeoutW-1:0]  timeout_reg   = TimeoutRst;
  logic [HoldW-1:0]     hold_reg      = HoldRst;

  // Sequencer copy
  seq_e                  seq_phase  = SEQ_IDLE;
  logic [SampleBits-1:0] shift_code = '0;
  int unsigned           bit_count  = 0;
  int unsigned           conv_count = 0;
  logic [33:0]           code_sum   = '0;
  int unsigned           ready_wait = 0;
  int unsigned           hold_count = 0;
  logic                  clk_level  = 1'b0;

  function automatic int unsigned count_eff();
    if (avg_count_reg == 0) return 1;
    if (avg_count_reg > MaxAverageDef) return MaxAverageDef;
    return avg_count_reg;
  endfunction

  function automatic int unsigned hold_eff();
    return (hold_reg == 0) ? 1 : hold_reg;
  endfunction

  function automatic readout_t advance_readout(logic [ReqW-1:0] req, logic pin);
    readout_t r;
    r = '0;
    case (seq_phase)
      SEQ_IDLE: begin
        if (req == REQ_READ) begin
          code_sum   = '0;
          conv_count = 0;
          ready_wait = 0;
          clk_level  = 1'b0;
          seq_phase  = SEQ_WAIT_READY;
        end else if (req == REQ_RESET || req == REQ_PDOWN) begin
          hold_count = 1;
          clk_level  = 1'b1;
          seq_phase  = (req == REQ_RESET) ? SEQ_RST_HOLD : SEQ_PD_HOLD;
        end
      end
      SEQ_WAIT_READY: begin
        if (!pin) begin
          shift_code = '0;
          bit_count  = 0;
          clk_level  = 1'b1;
          seq_phase  = SEQ_CLK_HIGH;
        end else begin
          ready_wait++;
          if (ready_wait >= timeout_reg) begin
            r.done    = 1'b1;
            r.status  = 1'b1;
            clk_level = 1'b0;
            seq_phase = SEQ_IDLE;
          end
        end
      end
      SEQ_CLK_HIGH: begin
        clk_level = 1'b0;
        seq_phase = SEQ_CLK_LOW;
      end
      SEQ_CLK_LOW: begin
        shift_code = {shift_code[SampleBits-2:0], pin};
        bit_count++;
        clk_level = 1'b1;
        seq_phase = (bit_count >= SampleBits) ? SEQ_RELEASE : SEQ_CLK_HIGH;
      end
      SEQ_RELEASE: begin
        clk_level = 1'b0;
        code_sum  = code_sum + (shift_code ^ TopBit);
        conv_count++;
        if (conv_count >= count_eff()) begin
          seq_phase = SEQ_FINISH;
        end else begin
          ready_wait = 0;
          seq_phase  = SEQ_WAIT_READY;
        end
      end
      SEQ_FINISH: begin
        r.done    = 1'b1;
        r.status  = !pin;
        r.code    = SampleBits'(code_sum / count_eff());
        clk_level = 1'b0;
        seq_phase = SEQ_IDLE;
      end
      SEQ_RST_HOLD: begin
        if (hold_count >= hold_eff()) begin
          clk_level = 1'b0;
          seq_phase = SEQ_RST_END;
        end else begin
          hold_count++;
        end
      end
      SEQ_RST_END: begin
        r.done    = 1'b1;
        r.status  = !pin;
        seq_phase = SEQ_IDLE;
      end
      SEQ_PD_HOLD: begin
        if (hold_count >= hold_eff()) begin
          r.done    = 1'b1;
          r.status  = !pin;
          seq_phase = SEQ_IDLE;
        end else begin
          hold_count++;
        end
      end
      default: begin
        seq_phase = SEQ_IDLE;
      end
    endcase
    r.clock_pin = clk_level;
    r.busy      = (seq_phase != SEQ_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < PrintLimit) begin
      $display("mismatch on %s at readout %0d: got %0h, want %0h", what, readout_count, got,
               want);
    end
    error_count++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_type_i <= REQ_TICK;
      data_pin_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_readouts.push_back(advance_readout(req_type_i, data_pin_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i <= 1'b1;
          req_type_i <= pending_ticks[0].req;
          data_pin_i <= pending_ticks[0].pin;
          pending_ticks.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (stall_req != stall_ack) begin
      stall_ack   = stall_req;
      stall_left  = StallCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_readouts.size() == 0) begin
        report_mismatch("unexpected readout", 32'd0, 32'd0);
      end else begin
        want_readout = expected_readouts.pop_front();
        if (clock_pin_o !== want_readout.clock_pin)
          report_mismatch("clock_pin", 32'(clock_pin_o), 32'(want_readout.clock_pin));
        if (done_res_o !== want_readout.done)
          report_mismatch("done_res", 32'(done_res_o), 32'(want_readout.done));
        if (status_o !== want_readout.status)
          report_mismatch("status", 32'(status_o), 32'(want_readout.status));
        if (average_code_o !== want_readout.code)
          report_mismatch("average_code", 32'(average_code_o), 32'(want_readout.code));
        if (busy_res_o !== want_readout.busy)
          report_mismatch("busy_res", 32'(busy_res_o), 32'(want_readout.busy));
      end
      readout_count++;
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic push_tick(logic [ReqW-1:0] req, logic pin);
    pending_ticks.push_back('{req: req, pin: pin});
    ticks_queued++;
  endtask

  function automatic logic [ReqW-1:0] noise_req();
    return ($urandom_range(99) < 70) ? REQ_TICK : ReqW'($urandom_range(3));
  endfunction

  function automatic logic [SampleBits-1:0] pick_code();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return ~TopBit;
      3:       return TopBit;
      default: return SampleBits'($urandom);
    endcase
  endfunction

  task automatic queue_read(logic [SampleBits-1:0] fixed_code, bit use_fixed,
                            int unsigned fail_pct);
    int unsigned n;
    int unsigned h;
    int unsigned hmax;
    logic [SampleBits-1:0] code;
    push_tick(REQ_READ, 1'($urandom_range(1)));
    n = count_eff();
    for (int unsigned c = 0; c < n; c++) begin
      if (timeout_reg <= 12 && $urandom_range(99) < fail_pct) begin
        h = (timeout_reg == 0) ? 1 : timeout_reg;
        repeat (h) push_tick(noise_req(), 1'b1);
        return;
      end
      hmax = (timeout_reg == 0) ? 0 : timeout_reg - 1;
      if (hmax > 4) hmax = 4;
      h = $urandom_range(hmax);
      repeat (h) push_tick(noise_req(), 1'b1);
      push_tick(noise_req(), 1'b0);
      code = use_fixed ? fixed_code : pick_code();
      for (int b = SampleBits - 1; b >= 0; b--) begin
        push_tick(noise_req(), 1'($urandom_range(1)));
        push_tick(noise_req(), code[b]);
      end
      push_tick(noise_req(), 1'($urandom_range(1)));
    end
    push_tick(noise_req(), ($urandom_range(3) != 0));
  endtask

  task automatic queue_cut_read(logic [SampleBits-1:0] code, int unsigned n_conv);
    push_tick(REQ_READ, 1'b1);
    repeat (n_conv) begin
      push_tick(noise_req(), 1'b0);
      for (int b = SampleBits - 1; b >= 0; b--) begin
        push_tick(noise_req(), 1'($urandom_range(1)));
        push_tick(noise_req(), code[b]);
      end
      push_tick(noise_req(), 1'($urandom_range(1)));
    end
    repeat ((timeout_reg == 0) ? 1 : timeout_reg) push_tick(noise_req(), 1'b1);
  endtask

  task automatic queue_hold(logic [ReqW-1:0] req);
    int unsigned n;
    push_tick(req, 1'($urandom_range(1)));
    n = (req == REQ_RESET) ? hold_eff() + 1 : hold_eff();
    repeat (n) push_tick(noise_req(), 1'($urandom_range(1)));
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (addr)
      CFG_AVG_COUNT: avg_count_reg = data[AvgCountW-1:0];
      CFG_TIMEOUT:   timeout_reg   = data[TimeoutW-1:0];
      CFG_HOLD:      hold_reg      = data[HoldW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_all_done();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || expected_readouts.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_settings();
    int unsigned t;
    write_reg(CFG_AVG_COUNT, ($urandom_range(4) == 0) ? '0 : CfgDataW'($urandom_range(1, 3)));
    case ($urandom_range(3))
      0:       t = 0;
      1:       t = $urandom_range(1, 6);
      2:       t = $urandom_range(7, 12);
      default: t = $urandom_range(100, (1 << TimeoutW) - 1);
    endcase
    write_reg(CFG_TIMEOUT, CfgDataW'(t));
    write_reg(CFG_HOLD, ($urandom_range(5) == 0) ? '0 : CfgDataW'($urandom_range(1, 8)));
  endtask

  task automatic run_random(int unsigned n_ticks);
    int unsigned start;
    int unsigned pick;
    start = ticks_queued;
    while (ticks_queued - start < n_ticks) begin
      while (pending_ticks.size() > 64) @(negedge clk_i);
      pick = $urandom_range(99);
      if (pick < 55) begin
        queue_read('0, 1'b0, 30);
      end else if (pick < 72) begin
        queue_hold(REQ_RESET);
      end else if (pick < 85) begin
        queue_hold(REQ_PDOWN);
      end else begin
        repeat ($urandom_range(1, 4)) push_tick(REQ_TICK, 1'($urandom_range(1)));
      end
      if ($urandom_range(99) < 3) wait_all_done();
    end
  endtask

  initial begin
    int unsigned waited;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults first
    push_tick(REQ_TICK, 1'b0);
    push_tick(REQ_TICK, 1'b1);
    queue_read(TopBit, 1'b1, 0);
    queue_hold(REQ_PDOWN);
    queue_hold(REQ_RESET);
    wait_all_done();

    write_reg(CFG_AVG_COUNT, '0);
    write_reg(CFG_TIMEOUT, '0);
    write_reg(CFG_HOLD, '0);
    queue_read('0, 1'b0, 100);
    queue_read(~TopBit, 1'b1, 0);
    queue_hold(REQ_RESET);
    queue_hold(REQ_PDOWN);
    wait_all_done();

    write_reg(CFG_AVG_COUNT, CfgDataW'(2));
    write_reg(CFG_TIMEOUT, CfgDataW'(3));
    write_reg(CFG_HOLD, CfgDataW'(1));
    queue_read('0, 1'b0, 50);
    queue_read('0, 1'b0, 0);
    wait_all_done();

    // Sender busy, receiver often stalled; long receiver hold-off at the start
    stall_req++;
    repeat (3) begin
      wait_all_done();
      random_settings();
      run_random(100);
    end

    tx_idle_pct = 52;
    rx_idle_pct = 20;
    repeat (3) begin
      wait_all_done();
      random_settings();
      run_random(100);
    end

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (3) begin
      wait_all_done();
      random_settings();
      run_random(100);
    end

    // Saturated count cut short by a timeout, then the widest timeout
    wait_all_done();
    write_reg(CFG_AVG_COUNT, '1);
    write_reg(CFG_TIMEOUT, CfgDataW'(5));
    queue_cut_read(~TopBit, 6);
    wait_all_done();
    write_reg(CFG_AVG_COUNT, CfgDataW'(1));
    write_reg(CFG_TIMEOUT, '1);
    queue_read(~TopBit, 1'b1, 0);
    queue_hold(REQ_PDOWN);

    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i);
    waited = 0;
    while (expected_readouts.size() != 0 && waited < 10000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_readouts.size() != 0) begin
      report_mismatch("readouts never delivered", 32'(expected_readouts.size()), 32'd0);
    end

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
